// ===== rtl/bwi_pkg.sv =====
// ----------------------------------------------------------------------------
// bwi_pkg
// Shared types and constants of the bicubic window interpolator.
// ----------------------------------------------------------------------------
package bwi_pkg;

	localparam int PIX_W       = 8;                  // pixel width
	localparam int PIX_PER_ROW = 4;                  // window width and height
	localparam int CUB_STAGES  = 4;                  // register stages of one cubic
	localparam int PIPE_STAGES = 2 * CUB_STAGES + 1; // two cubics and the output register

	localparam logic [PIX_W-1:0] PIX_MIN = '0;
	localparam logic [PIX_W-1:0] PIX_MAX = '1;

	// Load enables of the four stages of one cubic unit
	typedef struct packed {
		logic c1;
		logic c2;
		logic c3;
		logic c4;
	} cub_adv_t;

endpackage

// ===== rtl/bicubic_window_interpolator.sv =====
// ----------------------------------------------------------------------------
// bicubic_window_interpolator
// Catmull-Rom bicubic interpolation of one pixel from a 4x4 window.
// ----------------------------------------------------------------------------
//  channel | handshake           | payload
//  --------+---------------------+---------------------------------------------
//  in      | in_valid / in_stall | row0..row3_pixels, column_frac, row_frac,
//          |                     | copy_center
//  out     | out_valid/out_stall | pixel_out
//
//  One transaction in and one out per clock when neither side stalls.
//  Four stages of the row cubics, four of the column cubic and the output
//  register make up the pipeline; the three chained multiplies set the depth.
//  Reset clears only the stage valid bits, not the datapath registers.
//  An output stall holds the output register while upstream stages advance
//  into empty slots; in_stall rises only once every stage is full.
// ----------------------------------------------------------------------------
module bicubic_window_interpolator
	import bwi_pkg::*;
#(
	parameter int FRAC_BITS = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [31:0] row0_pixels,
	input  logic [31:0] row1_pixels,
	input  logic [31:0] row2_pixels,
	input  logic [31:0] row3_pixels,
	input  logic [7:0]  column_frac,
	input  logic [7:0]  row_frac,
	input  logic        copy_center,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  pixel_out
);

	localparam int HSW = FRAC_BITS + PIX_W + 1; // row sample width
	localparam int VSW = HSW + 4;               // column sample width
	localparam int RW  = VSW + 4;               // column result width
	localparam int WW  = RW - FRAC_BITS;        // integer part of the result
	localparam int EW  = FRAC_BITS + 8;         // fraction scaling width

	// Sideband that rides alongside the cubics
	typedef struct packed {
		logic                 copy;
		logic [PIX_W-1:0]     center;
		logic [FRAC_BITS-1:0] ty;
	} side_t;

	logic [PIPE_STAGES-1:0] vld_q;
	logic [PIPE_STAGES-1:0] stage_en;
	side_t                  side_q [CUB_STAGES*2];
	side_t                  side_in;

	logic [31:0]          rows [PIX_PER_ROW];
	logic [FRAC_BITS-1:0] tx, ty;
	logic signed [VSW-1:0] row_res [PIX_PER_ROW];
	logic signed [RW-1:0]  col_res;
	logic signed [WW-1:0]  whole;
	logic [PIX_W-1:0]      sat_pix;
	logic [PIX_W-1:0]      pixel_s9;
	cub_adv_t              h_adv, v_adv;

	// ---- stage enables: a stage loads when empty or when its successor moves
	always_comb begin
		stage_en[PIPE_STAGES-1] = !vld_q[PIPE_STAGES-1] || !out_stall;
		for (int i = PIPE_STAGES - 2; i >= 0; i--) begin
			stage_en[i] = !vld_q[i] || stage_en[i+1];
		end
	end

	assign in_stall = !stage_en[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (stage_en[0]) begin
				vld_q[0] <= in_valid;
			end
			for (int i = 1; i < PIPE_STAGES; i++) begin
				if (stage_en[i]) begin
					vld_q[i] <= vld_q[i-1];
				end
			end
		end
	end

	assign h_adv = '{c1: stage_en[0], c2: stage_en[1], c3: stage_en[2], c4: stage_en[3]};
	assign v_adv = '{c1: stage_en[4], c2: stage_en[5], c3: stage_en[6], c4: stage_en[7]};

	// ---- fractions: rescale Q0.8 to Q0.FRAC_BITS, flooring when narrower
	assign tx = FRAC_BITS'((EW'(column_frac) << FRAC_BITS) >> 8);
	assign ty = FRAC_BITS'((EW'(row_frac) << FRAC_BITS) >> 8);

	// ---- sideband shift line: hold copy flag, centre pixel and row fraction
	assign side_in = '{copy: copy_center, center: row1_pixels[15:8], ty: ty};

	always_ff @(posedge clk) begin
		if (stage_en[0]) begin
			side_q[0] <= side_in;
		end
		for (int i = 1; i < CUB_STAGES * 2; i++) begin
			if (stage_en[i]) begin
				side_q[i] <= side_q[i-1];
			end
		end
	end

	// ---- row cubics: one lane per window row, column fraction
	assign rows[0] = row0_pixels;
	assign rows[1] = row1_pixels;
	assign rows[2] = row2_pixels;
	assign rows[3] = row3_pixels;

	for (genvar r = 0; r < PIX_PER_ROW; r++) begin : g_row
		bwi_cubic #(
			.FRAC_BITS (FRAC_BITS),
			.SW        (HSW)
		) u_row_cubic (
			.clk (clk),
			.adv (h_adv),
			.t   (tx),
			.p0  ($signed({1'b0, rows[r][7:0],   {FRAC_BITS{1'b0}}})),
			.p1  ($signed({1'b0, rows[r][15:8],  {FRAC_BITS{1'b0}}})),
			.p2  ($signed({1'b0, rows[r][23:16], {FRAC_BITS{1'b0}}})),
			.p3  ($signed({1'b0, rows[r][31:24], {FRAC_BITS{1'b0}}})),
			.res (row_res[r])
		);
	end

	// ---- column cubic over the four row results, row fraction
	bwi_cubic #(
		.FRAC_BITS (FRAC_BITS),
		.SW        (VSW)
	) u_col_cubic (
		.clk (clk),
		.adv (v_adv),
		.t   (side_q[CUB_STAGES-1].ty),
		.p0  (row_res[0]),
		.p1  (row_res[1]),
		.p2  (row_res[2]),
		.p3  (row_res[3]),
		.res (col_res)
	);

	// ---- output stage: floor to an integer, saturate, or take the copy path
	assign whole = WW'(col_res >>> FRAC_BITS);

	always_comb begin
		if (whole[WW-1]) begin
			sat_pix = PIX_MIN;
		end else if (|whole[WW-2:PIX_W]) begin
			sat_pix = PIX_MAX;
		end else begin
			sat_pix = whole[PIX_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (stage_en[PIPE_STAGES-1]) begin
			pixel_s9 <= side_q[CUB_STAGES*2-1].copy ? side_q[CUB_STAGES*2-1].center
			                                        : sat_pix;
		end
	end

	assign out_valid = vld_q[PIPE_STAGES-1];
	assign pixel_out = pixel_s9;

	// ---- assertions
	// Input backs up exactly when every stage is full and the output stalls
	assert property (@(posedge clk) disable iff (!arst_n)
		in_stall == ((&vld_q) && out_stall))
	else $error("input stall does not match pipeline occupancy");

	// Transactions in flight change only by accepted inputs and outputs
	assert property (@(posedge clk) disable iff (!arst_n)
		$past(arst_n) |->
		$countones(vld_q) == $countones($past(vld_q))
			+ int'($past(in_valid && !in_stall))
			- int'($past(out_valid && !out_stall)))
	else $error("transaction lost or duplicated in pipeline");

	// An accepted transaction always occupies the first stage next cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> vld_q[0])
	else $error("accepted transaction not captured");

endmodule

// ===== rtl/bwi_cubic.sv =====
// ----------------------------------------------------------------------------
// bwi_cubic
// Four-stage Catmull-Rom cubic on signed fixed-point samples.
// ----------------------------------------------------------------------------
module bwi_cubic
	import bwi_pkg::*;
#(
	parameter int FRAC_BITS = 8,
	parameter int SW        = 17
) (
	input  logic                    clk,
	input  cub_adv_t                adv,
	input  logic [FRAC_BITS-1:0]    t,
	input  logic signed [SW-1:0]    p0,
	input  logic signed [SW-1:0]    p1,
	input  logic signed [SW-1:0]    p2,
	input  logic signed [SW-1:0]    p3,
	output logic signed [SW+3:0]    res
);

	localparam int IW = SW + 5;
	localparam int TW = FRAC_BITS + 1;
	localparam int PW = TW + IW;

	logic signed [IW-1:0] pe0, pe1, pe2, pe3;
	logic signed [IW-1:0] dif12, coef_a, coef_b0, coef_b, coef_c;
	logic signed [TW-1:0] t_c1, t_c2, t_c3;
	logic signed [PW-1:0] prod_a, prod_b, prod_c;

	logic signed [PW-1:0] prod_a_s1, prod_b_s2, prod_c_s3;
	logic signed [IW-1:0] b0_s1, d0_s1, d0_s2;
	logic signed [SW-1:0] p1_s1, p1_s2, p1_s3;
	logic [FRAC_BITS-1:0] t_s1, t_s2;
	logic signed [SW+3:0] res_s4;

	// Stage 1: cubic coefficient and first product
	assign pe0     = IW'(p0);
	assign pe1     = IW'(p1);
	assign pe2     = IW'(p2);
	assign pe3     = IW'(p3);
	assign dif12   = pe1 - pe2;
	assign coef_a  = dif12 + (dif12 <<< 1) + pe3 - pe0;
	assign coef_b0 = (pe0 <<< 1) - (pe1 <<< 2) - pe1 + (pe2 <<< 2) - pe3;
	assign t_c1    = $signed({1'b0, t});
	assign prod_a  = t_c1 * coef_a;

	always_ff @(posedge clk) begin
		if (adv.c1) begin
			prod_a_s1 <= prod_a;
			b0_s1     <= coef_b0;
			d0_s1     <= pe2 - pe0;
			p1_s1     <= p1;
			t_s1      <= t;
		end
	end

	// Stage 2: quadratic coefficient and second product
	assign coef_b = b0_s1 + IW'(prod_a_s1 >>> FRAC_BITS);
	assign t_c2   = $signed({1'b0, t_s1});
	assign prod_b = t_c2 * coef_b;

	always_ff @(posedge clk) begin
		if (adv.c2) begin
			prod_b_s2 <= prod_b;
			d0_s2     <= d0_s1;
			p1_s2     <= p1_s1;
			t_s2      <= t_s1;
		end
	end

	// Stage 3: linear coefficient and last product
	assign coef_c = d0_s2 + IW'(prod_b_s2 >>> FRAC_BITS);
	assign t_c3   = $signed({1'b0, t_s2});
	assign prod_c = t_c3 * coef_c;

	always_ff @(posedge clk) begin
		if (adv.c3) begin
			prod_c_s3 <= prod_c;
			p1_s3     <= p1_s2;
		end
	end

	// Stage 4: halve and floor the last product in one shift, add the base sample
	always_ff @(posedge clk) begin
		if (adv.c4) begin
			res_s4 <= (SW+4)'(p1_s3) + (SW+4)'(prod_c_s3 >>> (FRAC_BITS + 1));
		end
	end

	assign res = res_s4;

endmodule
